### hw/rtl/dbt_pkg.sv
// ============================================================================
// dbt_pkg - shared types and constants for the brew timer
// Command codes, outcome codes, configuration register indexes, field widths
// and reset values used by the debounced button brew timer.
// ============================================================================
`default_nettype none

package dbt_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int SECS_W     = 16;
    localparam int DBS_W      = 8;
    localparam int TPS_W      = 10;
    localparam int OUTCOME_W  = 2;
    localparam int TICKS_W    = 26;     // width of ticks_remaining on the bus
    localparam int PROD_W     = SECS_W + TPS_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;     // 17 payload bits padded to bytes
    localparam int S_USER_W   = CMD_W;
    localparam int M_DATA_W   = 32;     // 30 payload bits padded to bytes

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    // Outcome of the last run
    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_NONE      = 2'd0,
        OUTCOME_CANCELLED = 2'd1,
        OUTCOME_COMPLETED = 2'd2
    } outcome_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_DURATION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_SAMPLES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

    // Configuration reset values
    localparam logic [SECS_W-1:0] DEFAULT_DURATION_RST = 16'd300;
    localparam logic [DBS_W-1:0]  DEBOUNCE_SAMPLES_RST = 8'd5;
    localparam logic [TPS_W-1:0]  TICKS_PER_SECOND_RST = 10'd100;

    // One result beat
    typedef struct packed {
        logic [TICKS_W-1:0]   ticks_remaining;
        logic                 button_click;
        logic [OUTCOME_W-1:0] last_result;
        logic                 relay_on;
    } result_t;

endpackage : dbt_pkg

`default_nettype wire

### hw/rtl/debounced_button_brew_timer.sv
// ============================================================================
// debounced_button_brew_timer - timed relay controller with button debounce
// Ticks carry the raw button level into a same-level debouncer; a debounced
// press toggles the run. Commands start, stop or finish a run directly.
// ============================================================================
//
// Every accepted beat produces exactly one result beat. The whole update
// (debounce, countdown, run length multiply of seconds by ticks per second)
// is done in the cycle the beat is accepted, so one beat is taken per clock
// while s_tready is high. Results are registered in a two-entry buffer
// that decouples the sides; s_tready only drops while both entries are held.
// Configuration writes belong in idle periods.
//
`default_nettype none

module debounced_button_brew_timer
    import dbt_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 26
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,  // [0] button_level, [16:1] run_secs
    input  wire logic [S_USER_W-1:0]   s_tuser,  // [1:0] cmd

    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata   // [0] relay_on, [2:1] last_result,
                                                 // [3] button_click, [29:4] ticks_remaining
);

    localparam int TC = TICK_COUNT_BITS;
    localparam logic [TC-1:0] TC_ONE = {{(TC-1){1'b0}}, 1'b1};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SECS_W-1:0] default_duration_reg;
    logic [DBS_W-1:0]  debounce_samples_reg;
    logic [TPS_W-1:0]  ticks_per_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duration_reg <= DEFAULT_DURATION_RST;
            debounce_samples_reg <= DEBOUNCE_SAMPLES_RST;
            ticks_per_second_reg <= TICKS_PER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEFAULT_DURATION: default_duration_reg <= cfg_wdata;
                CFG_DEBOUNCE_SAMPLES: debounce_samples_reg <= cfg_wdata[DBS_W-1:0];
                CFG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_wdata[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Unit state
    // ------------------------------------------------------------------
    logic              raw_level_reg,    raw_level_next;
    logic              stable_level_reg, stable_level_next;
    logic [DBS_W-1:0]  same_count_reg,   same_count_next;
    logic              running_reg,      running_next;
    logic [TC-1:0]     ticks_left_reg,   ticks_left_next;
    outcome_t          outcome_reg,      outcome_next;

    // Input beat fields
    cmd_t              in_cmd;
    logic              in_level;
    logic [SECS_W-1:0] in_secs;
    logic              s_accept;

    assign in_cmd   = cmd_t'(s_tuser[CMD_W-1:0]);
    assign in_level = s_tdata[0];
    assign in_secs  = s_tdata[SECS_W:1];
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Run length: seconds times ticks per second, saturated
    // ------------------------------------------------------------------
    logic [SECS_W-1:0] mul_secs;
    logic [PROD_W-1:0] run_product;
    logic [TC-1:0]     run_len;

    // A start with a nonzero duration uses it; button starts use the default
    assign mul_secs = (in_cmd == CMD_START && in_secs != '0) ? in_secs : default_duration_reg;
    assign run_product = {{TPS_W{1'b0}}, mul_secs} * {{SECS_W{1'b0}}, ticks_per_second_reg};

    generate
        if (TC > PROD_W)
        begin : g_len_wide
            assign run_len = {{(TC-PROD_W){1'b0}}, run_product};
        end
        else if (TC == PROD_W)
        begin : g_len_equal
            assign run_len = run_product;
        end
        else
        begin : g_len_sat
            assign run_len = (run_product[PROD_W-1:TC] != '0) ? {TC{1'b1}}
                                                               : run_product[TC-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Next-state logic for one beat
    // ------------------------------------------------------------------
    logic click_next;

    always_comb
    begin
        raw_level_next    = raw_level_reg;
        stable_level_next = stable_level_reg;
        same_count_next   = same_count_reg;
        running_next      = running_reg;
        ticks_left_next   = ticks_left_reg;
        outcome_next      = outcome_reg;
        click_next        = 1'b0;

        case (in_cmd)
            CMD_TICK:
            begin
                if (in_level != raw_level_reg)
                begin
                    // level changed: restart the count
                    raw_level_next  = in_level;
                    same_count_next = '0;
                end
                else if (same_count_reg >= debounce_samples_reg)
                begin
                    // settled: count the run down
                    if (running_reg && ticks_left_reg != '0)
                    begin
                        if (ticks_left_reg == TC_ONE)
                        begin
                            ticks_left_next = '0;
                            outcome_next    = OUTCOME_COMPLETED;
                            running_next    = 1'b0;
                        end
                        else
                        begin
                            ticks_left_next = ticks_left_reg - TC_ONE;
                        end
                    end
                end
                else
                begin
                    same_count_next = same_count_reg + 8'd1;
                    if (same_count_next == debounce_samples_reg &&
                        in_level != stable_level_reg)
                    begin
                        stable_level_next = in_level;
                        if (!in_level)
                        begin
                            // debounced press toggles the run
                            click_next = 1'b1;
                            if (!running_reg)
                            begin
                                ticks_left_next = run_len;
                                outcome_next    = OUTCOME_NONE;
                                running_next    = 1'b1;
                            end
                            else
                            begin
                                ticks_left_next = '0;
                                outcome_next    = OUTCOME_CANCELLED;
                                running_next    = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_START:
            begin
                ticks_left_next = run_len;
                outcome_next    = OUTCOME_NONE;
                running_next    = 1'b1;
            end
            CMD_STOP:
            begin
                if (running_reg)
                begin
                    outcome_next = OUTCOME_CANCELLED;
                end
                ticks_left_next = '0;
                running_next    = 1'b0;
            end
            CMD_FINISH:
            begin
                ticks_left_next = '0;
                outcome_next    = OUTCOME_COMPLETED;
                running_next    = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg    <= 1'b1;
            stable_level_reg <= 1'b1;
            same_count_reg   <= '0;
            running_reg      <= 1'b0;
            ticks_left_reg   <= '0;
            outcome_reg      <= OUTCOME_NONE;
        end
        else if (s_accept)
        begin
            raw_level_reg    <= raw_level_next;
            stable_level_reg <= stable_level_next;
            same_count_reg   <= same_count_next;
            running_reg      <= running_next;
            ticks_left_reg   <= ticks_left_next;
            outcome_reg      <= outcome_next;
        end
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    logic [TICKS_W-1:0] ticks_out;
    result_t            result_next;

    generate
        if (TC >= TICKS_W)
        begin : g_out_trunc
            assign ticks_out = ticks_left_next[TICKS_W-1:0];
        end
        else
        begin : g_out_ext
            assign ticks_out = {{(TICKS_W-TC){1'b0}}, ticks_left_next};
        end
    endgenerate

    always_comb
    begin
        result_next.relay_on        = running_next;
        result_next.last_result     = outcome_next;
        result_next.button_click    = click_next;
        result_next.ticks_remaining = ticks_out;
    end

    // ------------------------------------------------------------------
    // Two-entry result buffer
    // ------------------------------------------------------------------
    result_t     res_buf_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        m_accept;

    assign m_accept = m_tvalid && m_tready;
    assign s_tready = (fill_reg != 2'd2);
    assign m_tvalid = (fill_reg != 2'd0);
    assign m_tdata  = {{(M_DATA_W-$bits(result_t)){1'b0}}, res_buf_reg[rd_ptr_reg]};

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            res_buf_reg[wr_ptr_reg] <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (s_accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (m_accept)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (s_accept && !m_accept)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!s_accept && m_accept)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("result buffer fill out of range");

    a_idle_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> ticks_left_reg == '0)
        else $error("ticks left while relay is off");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (in_cmd == CMD_STOP || in_cmd == CMD_FINISH) |=> !running_reg)
        else $error("relay still on after stop or finish");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && in_cmd == CMD_START |=> running_reg && outcome_reg == OUTCOME_NONE)
        else $error("start did not begin a run");

endmodule : debounced_button_brew_timer

`default_nettype wire
